/* hw/rtl/lpd_pkg.sv */
// Shared types and constants for the length-prefix deframer.
// Holds the input and result word layouts and the result kind codes.
// No dependencies.
package lpd_pkg;

	localparam int unsigned CAP_W = 24;
	localparam int unsigned LEN_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 24'd1024;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        chunk_end;
		logic [15:0] client_id;
		logic [15:0] instance_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       payload_byte;
		logic             last_of_message;
		logic [LEN_W-1:0] message_length;
		logic [15:0]      tag_client;
		logic [15:0]      tag_instance;
	} out_item_t;

endpackage

/* hw/rtl/lpd_skid.sv */
// Two-entry result buffer: output register plus one skid word.
// Depends on lpd_pkg for the result word layout.
module lpd_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lpd_pkg::out_item_t push_data,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output lpd_pkg::out_item_t out_data
);

	logic               out_vld_q;
	logic               skid_vld_q;
	lpd_pkg::out_item_t out_q;
	lpd_pkg::out_item_t skid_q;

	assign room      = !skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			out_q <= skid_vld_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q) else $error("skid word without output word");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_vld_q) else $error("push into full buffer");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && out_ready |=> out_vld_q && !skid_vld_q)
		else $error("skid word not moved to output");

endmodule

/* hw/rtl/length_prefix_deframer.sv */
// Length-prefix deframer top level.
// Depends on lpd_pkg and lpd_skid.
//
// Usage: stream bytes enter on in_valid/in_ready/in_data, one word per byte.
// The first PREFIX_BYTES bytes of each message form a little-endian length;
// the payload bytes that follow leave on out_valid/out_ready/out_data, each
// tagged with the ids of its input word and marked on the last byte.
// A zero-length message that fits gives one empty result; a message whose
// length plus prefix exceeds buffer_capacity gives one error result and
// its payload bytes are dropped. Dropped bytes and all prefix bytes but the
// last give no result. cfg_valid/cfg_ready/cfg_data write buffer_capacity;
// cfg_ready is always high. Write it only while no message is in flight.
// Throughput: one byte per cycle while in_ready is high; the framing counter
// and the capacity compare are both combinational between accept and the
// result register that drives out_valid.
// Stall: results sit in an output register backed by one skid word; in_ready
// drops only while both hold a result. Reset clears framing state, empties
// the result buffer and sets buffer_capacity to 1024.
module length_prefix_deframer #(
	parameter int unsigned PREFIX_BYTES = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  lpd_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output lpd_pkg::out_item_t         out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lpd_pkg::CAP_W-1:0]  cfg_data
);

	localparam int unsigned HCW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
	localparam logic [2:0] HC_LAST = 3'(PREFIX_BYTES - 1);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_SKIP    = 2'd2
	} phase_t;

	phase_t                          phase_q;
	logic [HCW-1:0]                  hdr_cnt_q;
	logic [lpd_pkg::LEN_W-1:0]       len_q;
	logic [lpd_pkg::LEN_W-1:0]       left_q;
	logic [lpd_pkg::CAP_W-1:0]       cap_q;

	logic                            accept;
	logic                            room;
	logic [2:0]                      hc;
	logic [lpd_pkg::LEN_W-1:0]       len_base;
	logic [lpd_pkg::LEN_W-1:0]       len_next;
	logic [lpd_pkg::LEN_W:0]         total;
	logic                            hdr_done;
	logic                            oversize;
	logic                            left_last;
	logic                            push;
	lpd_pkg::out_item_t              res;

	assign cfg_ready = 1'b1;
	assign in_ready  = room;
	assign accept    = in_valid && room;

	assign hc        = 3'(hdr_cnt_q);
	assign left_last = (left_q <= 32'd1);
	assign len_base  = (hc == 3'd0) ? '0 : len_q;

	always_comb begin
		len_next = len_base;
		if (hc < 3'd4) begin
			if (len_base != '1 || hc == 3'd0) begin
				len_next = len_base | ({24'd0, in_data.data_byte} << {hc[1:0], 3'b000});
			end
		end else if (in_data.data_byte != 8'd0) begin
			len_next = '1;
		end
	end

	assign hdr_done = (hc == HC_LAST);
	assign total    = {1'b0, len_next} + 33'(PREFIX_BYTES);
	assign oversize = total > {9'd0, cap_q};

	always_comb begin
		res.kind            = lpd_pkg::KIND_PAYLOAD;
		res.payload_byte    = 8'd0;
		res.last_of_message = 1'b1;
		res.message_length  = len_q;
		res.tag_client      = in_data.client_id;
		res.tag_instance    = in_data.instance_id;
		push                = 1'b0;
		case (phase_q)
			PH_PAYLOAD: begin
				res.payload_byte    = in_data.data_byte;
				res.last_of_message = left_last;
				push                = accept;
			end
			PH_SKIP: begin
				push = 1'b0;
			end
			default: begin
				res.message_length = len_next;
				if (oversize) begin
					res.kind = lpd_pkg::KIND_ERROR;
				end else begin
					res.kind = lpd_pkg::KIND_EMPTY;
				end
				push = accept && hdr_done && (oversize || len_next == '0);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lpd_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			len_q     <= '0;
			left_q    <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_PAYLOAD, PH_SKIP: begin
					if (left_last) begin
						left_q  <= '0;
						phase_q <= PH_HEADER;
					end else begin
						left_q <= left_q - 32'd1;
					end
				end
				default: begin
					len_q <= len_next;
					if (!hdr_done) begin
						hdr_cnt_q <= hdr_cnt_q + 1'b1;
						phase_q   <= PH_HEADER;
					end else begin
						hdr_cnt_q <= '0;
						if (oversize) begin
							left_q  <= len_next;
							phase_q <= (len_next == '0) ? PH_HEADER : PH_SKIP;
						end else if (len_next == '0) begin
							phase_q <= PH_HEADER;
						end else begin
							left_q  <= len_next;
							phase_q <= PH_PAYLOAD;
						end
					end
				end
			endcase
		end
	end

	lpd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		3'(hdr_cnt_q) <= HC_LAST) else $error("prefix count out of range");
	a_body_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD || phase_q == PH_SKIP) |-> left_q != '0)
		else $error("payload phase with nothing left");
	a_payload_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_PAYLOAD |=> out_valid)
		else $error("payload byte produced no result");
	a_header_mid_count: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q != '0 |-> phase_q == PH_HEADER)
		else $error("prefix count outside header phase");

endmodule

/* sim/lpd_frame_checker.sv */
// Scoreboard for the length-prefix deframer: watches the input, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on lpd_pkg for the word layouts and result kind codes.
module lpd_frame_checker #(
	parameter int unsigned PREFIX_BYTES = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  lpd_pkg::in_item_t          in_data,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  lpd_pkg::out_item_t         out_data,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [lpd_pkg::CAP_W-1:0]  cfg_data,
	output int                         fail_count,
	output int                         results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LEN_W = lpd_pkg::LEN_W;
	localparam int unsigned CAP_W = lpd_pkg::CAP_W;

	typedef enum logic [1:0] {
		FR_HEADER  = 2'd0,
		FR_PAYLOAD = 2'd1,
		FR_SKIP    = 2'd2
	} frame_phase_t;

	frame_phase_t            fr_phase;
	int unsigned             hdr_seen;
	logic [LEN_W-1:0]        decl_len;
	logic [LEN_W-1:0]        remaining;
	logic [CAP_W-1:0]        capacity;
	lpd_pkg::out_item_t      due_results[$];
	int                      mismatch_cnt;

	assign fail_count  = mismatch_cnt;

	task automatic deframe_word(input lpd_pkg::in_item_t w, output bit got,
		output lpd_pkg::out_item_t r);
		logic [LEN_W:0] total;
		got = 1'b0;
		r = '0;
		r.tag_client = w.client_id;
		r.tag_instance = w.instance_id;
		case (fr_phase)
			FR_PAYLOAD: begin
				got = 1'b1;
				r.kind = lpd_pkg::KIND_PAYLOAD;
				r.payload_byte = w.data_byte;
				r.message_length = decl_len;
				r.last_of_message = (remaining <= 1);
				if (remaining <= 1) begin
					remaining = '0;
					fr_phase = FR_HEADER;
				end else begin
					remaining = remaining - 1;
				end
			end
			FR_SKIP: begin
				if (remaining <= 1) begin
					remaining = '0;
					fr_phase = FR_HEADER;
				end else begin
					remaining = remaining - 1;
				end
			end
			default: begin
				fr_phase = FR_HEADER;
				if (hdr_seen == 0)
					decl_len = '0;
				if (hdr_seen < 4) begin
					if (decl_len != '1 || hdr_seen == 0)
						decl_len = decl_len | (LEN_W'(w.data_byte) << (8 * hdr_seen));
				end else if (w.data_byte != 8'd0) begin
					decl_len = '1;
				end
				hdr_seen = hdr_seen + 1;
				if (hdr_seen >= PREFIX_BYTES) begin
					hdr_seen = 0;
					total = {1'b0, decl_len} + (LEN_W + 1)'(PREFIX_BYTES);
					if (total > (LEN_W + 1)'(capacity)) begin
						got = 1'b1;
						r.kind = lpd_pkg::KIND_ERROR;
						r.last_of_message = 1'b1;
						r.message_length = decl_len;
						remaining = decl_len;
						fr_phase = (decl_len == 0) ? FR_HEADER : FR_SKIP;
					end else if (decl_len == 0) begin
						got = 1'b1;
						r.kind = lpd_pkg::KIND_EMPTY;
						r.last_of_message = 1'b1;
					end else begin
						remaining = decl_len;
						fr_phase = FR_PAYLOAD;
					end
				end
			end
		endcase
	endtask

	task automatic report(input string what, input lpd_pkg::out_item_t exp_r,
		input lpd_pkg::out_item_t act_r);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("%0t mismatch (%s): expected kind=%0d byte=%h last=%b len=%h cid=%h iid=%h",
				$realtime, what, exp_r.kind, exp_r.payload_byte, exp_r.last_of_message,
				exp_r.message_length, exp_r.tag_client, exp_r.tag_instance);
			$display("    got kind=%0d byte=%h last=%b len=%h cid=%h iid=%h",
				act_r.kind, act_r.payload_byte, act_r.last_of_message,
				act_r.message_length, act_r.tag_client, act_r.tag_instance);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lpd_pkg::out_item_t exp_r;
		lpd_pkg::out_item_t new_r;
		bit                 got;
		if (!arst_n) begin
			fr_phase = FR_HEADER;
			hdr_seen = 0;
			decl_len = '0;
			remaining = '0;
			capacity = lpd_pkg::CAP_RESET;
			due_results.delete();
			mismatch_cnt = 0;
			results_due = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report("unexpected result", '0, out_data);
				end else begin
					exp_r = due_results.pop_front();
					if (out_data.kind != exp_r.kind
						|| out_data.payload_byte != exp_r.payload_byte
						|| out_data.last_of_message != exp_r.last_of_message
						|| out_data.message_length != exp_r.message_length
						|| out_data.tag_client != exp_r.tag_client
						|| out_data.tag_instance != exp_r.tag_instance)
						report("field", exp_r, out_data);
				end
			end
			if (in_valid && in_ready) begin
				deframe_word(in_data, got, new_r);
				if (got)
					due_results.push_back(new_r);
			end
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			results_due = due_results.size();
		end
	end

endmodule

/* sim/length_prefix_deframer_tb.sv */
// Top-level testbench for the length-prefix deframer: drives framed byte
// streams and capacity writes with random gaps and gives the verdict.
// Depends on lpd_pkg, length_prefix_deframer and lpd_frame_checker.
module length_prefix_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAP_W = lpd_pkg::CAP_W;
	localparam int unsigned PB = 4;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_WORDS = 110;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	lpd_pkg::in_item_t   in_data;
	logic                out_valid;
	logic                out_ready;
	lpd_pkg::out_item_t  out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_W-1:0]    cfg_data;
	int                  fail_count;
	int                  results_due;

	int                  words_sent;
	int                  idle_cycles;
	logic [CAP_W-1:0]    cur_cap;
	bit                  in_calm;
	bit                  out_calm;
	int                  out_stall;

	length_prefix_deframer #(.PREFIX_BYTES(PB)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	lpd_frame_checker #(.PREFIX_BYTES(PB)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [15:0] pick_id();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	// advance the receiver's stall pattern, mostly short stalls, a few long
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready = 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				out_calm = !out_calm;
			if (out_stall > 0) begin
				out_ready = 1'b0;
				out_stall--;
			end else begin
				out_ready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					out_stall = pick_gap(out_calm);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic [15:0] cid,
		input logic [15:0] iid, input logic ce);
		int gap;
		if ($urandom_range(0, 49) == 0)
			in_calm = !in_calm;
		gap = pick_gap(in_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = {b, ce, cid, iid};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send_message(input logic [31:0] len, input bit scatter_ids);
		logic [15:0] cid;
		logic [15:0] iid;
		int unsigned i;
		cid = pick_id();
		iid = pick_id();
		for (i = 0; i < PB; i++)
			send_word((i < 4) ? len[8*i +: 8] : 8'd0, cid, iid, 1'($urandom_range(0, 1)));
		for (i = 0; i < len; i++) begin
			if (scatter_ids) begin
				cid = pick_id();
				iid = pick_id();
			end
			send_word(8'($urandom_range(0, 255)), cid, iid, 1'($urandom_range(0, 1)));
		end
	endtask

	// hold the input low until every result is out and the framing has settled
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cur_cap = value;
	endtask

	function automatic logic [31:0] pick_length(input logic [CAP_W-1:0] cap);
		int r;
		int edge_pct;
		logic [31:0] lim;
		lim = (cap >= PB) ? 32'(cap - PB) : 32'd0;
		edge_pct = (cap <= 64) ? 25 : ((cap <= 2000) ? 2 : 0);
		r = $urandom_range(0, 99);
		if (r < edge_pct)
			return (lim > 0) ? lim - 1 + $urandom_range(0, 2) : 32'($urandom_range(0, 2));
		if (r < edge_pct + 35)
			return $urandom_range(0, 3);
		if (r < 97 || lim < 300)
			return $urandom_range(4, 24);
		return $urandom_range(256, 300);
	endfunction

	task automatic run_phase(input logic [CAP_W-1:0] cap, input bit mid_pause);
		int stop_at;
		bit paused;
		paused = 1'b0;
		write_capacity(cap);
		stop_at = words_sent + PHASE_WORDS;
		while (words_sent < stop_at) begin
			send_message(pick_length(cur_cap), $urandom_range(0, 9) == 0);
			if (mid_pause && !paused && words_sent > stop_at - PHASE_WORDS / 2) begin
				drain();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		words_sent = 0;
		idle_cycles = 0;
		cur_cap = lpd_pkg::CAP_RESET;
		in_calm = 1'b0;
		out_calm = 1'b0;
		out_stall = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset capacity: empty, one byte with extreme ids, two bytes with scattered ids
		send_message(32'd0, 1'b0);
		send_word(8'd1, 16'hFFFF, 16'h0000, 1'b0);
		send_word(8'd0, 16'hFFFF, 16'h0000, 1'b1);
		send_word(8'd0, 16'hFFFF, 16'h0000, 1'b0);
		send_word(8'd0, 16'hFFFF, 16'h0000, 1'b1);
		send_word(8'hFF, 16'h0000, 16'hFFFF, 1'b1);
		send_message(32'd2, 1'b1);
		// zero capacity: zero length is oversize
		write_capacity('0);
		send_message(32'd0, 1'b0);
		send_message(32'd1, 1'b0);
		// capacity equals the prefix: empty fits, one byte does not
		write_capacity(CAP_W'(PB));
		send_message(32'd0, 1'b0);
		send_message(32'd1, 1'b0);

		run_phase(lpd_pkg::CAP_RESET, 1'b1);
		run_phase(CAP_W'(20), 1'b0);
		run_phase('0, 1'b0);
		run_phase(CAP_W'($urandom_range(5, 40)), 1'b1);
		run_phase('1, 1'b0);
		run_phase(CAP_W'(64), 1'b0);

		// largest capacity, all-ones length: oversize, then drop what follows
		write_capacity('1);
		repeat (PB) send_word(8'hFF, pick_id(), pick_id(), 1'b0);
		send_word(8'hFF, pick_id(), pick_id(), 1'b1);
		send_word(8'h00, pick_id(), pick_id(), 1'b0);
		send_word(8'h5A, pick_id(), pick_id(), 1'b1);

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && results_due == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
